// File: sv/mlcd_pkg.sv
// mouse-look camera direction: shared types, constants and helper functions
// no dependencies; imported by mlcd_cordic, the top level and the testbench
`default_nettype none

package mlcd_pkg;

	// widths of the fixed-point paths
	localparam int unsigned TABLE_LEN = 24;
	localparam int unsigned CNT_W     = 5;
	localparam int unsigned ANG_W     = 18;
	localparam int unsigned Z_W       = 25;
	localparam int unsigned XY_W      = 34;
	localparam int unsigned RND_W     = 36;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 16;

	localparam int unsigned TRIG_ITERATIONS_DEF = 16;

	// angle constants in 1/256 degree
	localparam logic signed [ANG_W-1:0] TURN_A    = 18'sd92160;
	localparam logic signed [ANG_W-1:0] HALF_A    = 18'sd46080;
	localparam logic signed [ANG_W-1:0] QUARTER_A = 18'sd23040;

	localparam logic signed [XY_W-1:0]  CORDIC_START = 34'sd652032874;
	localparam logic signed [RND_W-1:0] ONE_Q14_R    = 36'sd16384;
	localparam logic signed [RND_W-1:0] DELTA_MAX_R  = 36'sd92159;

	// register reset values
	localparam logic [15:0]        SENS_RST      = 16'd6554;
	localparam logic [14:0]        PLIM_RST      = 15'd22784;
	localparam logic [14:0]        PLIM_MAX      = 15'd23040;
	localparam logic signed [15:0] START_X_RST   = 16'sd400;
	localparam logic signed [15:0] START_Y_RST   = 16'sd300;
	localparam logic [16:0]        YAW_RST       = 17'd69120;
	localparam logic [5:0]         FOV_RST       = 6'd45;
	localparam logic signed [8:0]  FOV_MIN       = 9'sd1;
	localparam logic signed [8:0]  FOV_MAX       = 9'sd45;

	// operation codes
	localparam logic OP_MOVE   = 1'b0;
	localparam logic OP_SCROLL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSITIVITY = 8'd0,
		REG_PITCH_LIMIT = 8'd1,
		REG_START_X     = 8'd2,
		REG_START_Y     = 8'd3
	} mlcd_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE_X,
		ST_SCALE_Y,
		ST_UPDATE,
		ST_YAW_START,
		ST_TRIG_YAW,
		ST_TRIG_PITCH,
		ST_MUL_X,
		ST_MUL_Z,
		ST_FINISH
	} mlcd_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ITER,
		CS_ROUND
	} mlcd_cordic_state_t;

	// result of one sine/cosine pass
	typedef struct packed {
		logic               done;
		logic signed [15:0] sin_val;
		logic signed [15:0] cos_val;
	} mlcd_trig_rsp_t;

	// arctangent of 2^-i in 2^-16 degree
	function automatic logic [21:0] mlcd_atan(input logic [CNT_W-1:0] idx);
		logic [21:0] r;
		case (idx)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// shift right by sh rounding halves away from zero, then clamp to +/- lim
	function automatic logic signed [RND_W-1:0] sat_round(
		input logic signed [RND_W-1:0] v,
		input int unsigned             sh,
		input logic signed [RND_W-1:0] lim
	);
		logic signed [RND_W-1:0] half;
		logic signed [RND_W-1:0] mag;
		logic signed [RND_W-1:0] r;
		half = 36'sd1 <<< (sh - 1);
		mag  = v[RND_W-1] ? -v : v;
		r    = (mag + half) >>> sh;
		if (v[RND_W-1]) begin
			r = -r;
		end
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/mlcd_if.sv
// mouse-look camera direction: valid/ready channel interfaces
// input events, direction results and the configuration write channel
`default_nettype none

interface mlcd_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [15:0] cursor_x;
	logic signed [15:0] cursor_y;
	logic signed [7:0]  scroll_step;

	modport source (output valid, operation, cursor_x, cursor_y, scroll_step, input ready);
	modport sink   (input valid, operation, cursor_x, cursor_y, scroll_step, output ready);
endinterface

interface mlcd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic [16:0]        yaw_angle;
	logic signed [15:0] pitch_angle;
	logic [5:0]         fov_degrees;

	modport source (output valid, dir_x, dir_y, dir_z, yaw_angle, pitch_angle, fov_degrees,
		input ready);
	modport sink   (input valid, dir_x, dir_y, dir_z, yaw_angle, pitch_angle, fov_degrees,
		output ready);
endinterface

interface mlcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/mlcd_cordic.sv
// mouse-look camera direction: iterative rotation-mode sine/cosine unit
// one micro-rotation per cycle; depends on mlcd_pkg
`default_nettype none

module mlcd_cordic import mlcd_pkg::*; #(
	parameter int unsigned TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire logic signed [ANG_W-1:0] angle,
	output mlcd_trig_rsp_t               rsp
);

	localparam int unsigned ITERS =
		(TRIG_ITERATIONS > TABLE_LEN) ? TABLE_LEN : TRIG_ITERATIONS;
	localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ITERS - 1);

	mlcd_cordic_state_t state_q, state_d;
	logic [CNT_W-1:0]      iter_q;
	logic                  done_q;
	logic                  neg_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic signed [15:0]     sin_q, cos_q;

	logic load_en, step_en, round_en;

	// angle folding into -90..90 degrees
	logic signed [ANG_W-1:0] a_wrap, a_fold;
	logic                    a_neg;

	always_comb begin
		if (angle > HALF_A) begin
			a_wrap = angle - TURN_A;
		end else if (angle <= -HALF_A) begin
			a_wrap = angle + TURN_A;
		end else begin
			a_wrap = angle;
		end
		a_neg = 1'b1;
		if (a_wrap > QUARTER_A) begin
			a_fold = a_wrap - HALF_A;
		end else if (a_wrap < -QUARTER_A) begin
			a_fold = a_wrap + HALF_A;
		end else begin
			a_fold = a_wrap;
			a_neg  = 1'b0;
		end
	end

	// one micro-rotation
	logic signed [XY_W-1:0] xs, ys, x_n, y_n;
	logic signed [Z_W-1:0]  z_n, atan_v;
	logic                   rot_pos;

	always_comb begin
		xs      = x_q >>> iter_q;
		ys      = y_q >>> iter_q;
		atan_v  = signed'({3'b000, mlcd_atan(iter_q)});
		rot_pos = !z_q[Z_W-1];
		if (rot_pos) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - atan_v;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + atan_v;
		end
	end

	// final rounding to q1.14 with the half-turn sign
	logic signed [RND_W-1:0] x_r, y_r;
	logic signed [15:0]      cos_n, sin_n;

	always_comb begin
		x_r   = sat_round(RND_W'(x_q), 16, ONE_Q14_R);
		y_r   = sat_round(RND_W'(y_q), 16, ONE_Q14_R);
		cos_n = neg_q ? -x_r[15:0] : x_r[15:0];
		sin_n = neg_q ? -y_r[15:0] : y_r[15:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_d = CS_ITER;
				end
			end
			CS_ITER: begin
				if (iter_q == LAST_ITER) begin
					state_d = CS_ROUND;
				end
			end
			CS_ROUND: begin
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// datapath enables
	always_comb begin
		load_en  = 1'b0;
		step_en  = 1'b0;
		round_en = 1'b0;
		case (state_q)
			CS_IDLE:  load_en  = start;
			CS_ITER:  step_en  = 1'b1;
			CS_ROUND: round_en = 1'b1;
			default: begin
				load_en = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= round_en;
			if (load_en) begin
				iter_q <= '0;
			end else if (step_en) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	// rotation registers
	always_ff @(posedge clk) begin
		if (load_en) begin
			x_q   <= CORDIC_START;
			y_q   <= '0;
			z_q   <= {a_fold[16:0], 8'b0};
			neg_q <= a_neg;
		end else if (step_en) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
		if (round_en) begin
			sin_q <= sin_n;
			cos_q <= cos_n;
		end
	end

	assign rsp.done    = done_q;
	assign rsp.sin_val = sin_q;
	assign rsp.cos_val = cos_q;

endmodule

`default_nettype wire

// File: sv/mouse_look_camera_direction_top.sv
// mouse-look camera direction: top level with event sequencer and shared multiplier
// depends on mlcd_pkg, mlcd_if and mlcd_cordic
//
// usage
//   req carries one event per transaction: a cursor move (operation 0, cursor_x/y)
//   or a scroll (operation 1, scroll_step). rsp returns one transaction per event:
//   the q1.14 direction vector with the current yaw, pitch and field of view.
//   cfg writes sensitivity, pitch_limit, start_x and start_y by index 0..3; it is
//   always ready and is meant to be used only while no event is in flight.
// timing (TRIG_ITERATIONS is capped at 24)
//   a result becomes valid at the same edge at which req.ready returns, so the
//   block takes one event at a time; a scroll skips the scaling and update steps
//   of a cursor move. the two sine/cosine passes (yaw, then pitch) run one after
//   the other on a single iterative unit.
// reset and stall
//   arst_n restores the reset angles (yaw 270, pitch 0, fov 45) and registers.
//   results sit in an output register, so the next event is taken while a
//   result waits; a further finished result waits until rsp is taken.
`default_nettype none

module mouse_look_camera_direction_top import mlcd_pkg::*; #(
	parameter int unsigned TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	mlcd_in_if.sink   req,
	mlcd_out_if.source rsp,
	mlcd_cfg_if.sink  cfg
);

	mlcd_state_t state_q, state_d;

	// configuration and architectural state
	logic [15:0]        sens_q;
	logic [14:0]        plim_q;
	logic signed [15:0] last_x_q, last_y_q;
	logic [16:0]        yaw_q;
	logic signed [15:0] pitch_q;
	logic [5:0]         fov_q;

	// working registers
	logic signed [15:0] cx_q, cy_q;
	logic signed [33:0] prod_q;
	logic signed [17:0] dyaw_q;
	logic signed [15:0] sy_q, cy_trig_q, sp_q, cp_q, dirx_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] o_dir_x_q, o_dir_y_q, o_dir_z_q, o_pitch_q;
	logic [16:0]        o_yaw_q;
	logic [5:0]         o_fov_q;

	logic req_fire, cfg_fire, out_free;
	logic trig_start;
	logic signed [ANG_W-1:0] trig_angle;
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] mul_p;
	mlcd_trig_rsp_t trig_rsp;

	assign req_fire = req.valid && req.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	// shared sine/cosine unit
	mlcd_cordic #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (trig_start),
		.angle (trig_angle),
		.rsp   (trig_rsp)
	);

	// shared multiplier
	assign mul_p = mul_a * mul_b;

	// angle update arithmetic
	logic signed [17:0] dpitch;
	logic signed [18:0] yaw_sum, yaw_wrap, pitch_sum, pitch_lim, pitch_new;
	logic [14:0]        plim_eff;
	logic signed [8:0]  fov_sum, fov_new;
	logic signed [RND_W-1:0] scale_r, q14_r;

	always_comb begin
		scale_r  = sat_round(RND_W'(prod_q), 8, DELTA_MAX_R);
		q14_r    = sat_round(RND_W'(prod_q), 14, ONE_Q14_R);
		dpitch   = scale_r[17:0];
		yaw_sum  = signed'({2'b00, yaw_q}) + 19'(dyaw_q);
		if (yaw_sum < 19'sd0) begin
			yaw_wrap = yaw_sum + 19'(TURN_A);
		end else if (yaw_sum >= 19'(TURN_A)) begin
			yaw_wrap = yaw_sum - 19'(TURN_A);
		end else begin
			yaw_wrap = yaw_sum;
		end
		plim_eff  = (plim_q > PLIM_MAX) ? PLIM_MAX : plim_q;
		pitch_lim = signed'({4'b0000, plim_eff});
		pitch_sum = 19'(pitch_q) + 19'(dpitch);
		if (pitch_sum > pitch_lim) begin
			pitch_new = pitch_lim;
		end else if (pitch_sum < -pitch_lim) begin
			pitch_new = -pitch_lim;
		end else begin
			pitch_new = pitch_sum;
		end
		fov_sum = signed'({3'b000, fov_q}) - 9'(req.scroll_step);
		if (fov_sum > FOV_MAX) begin
			fov_new = FOV_MAX;
		end else if (fov_sum < FOV_MIN) begin
			fov_new = FOV_MIN;
		end else begin
			fov_new = fov_sum;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = (req.operation == OP_SCROLL) ? ST_YAW_START : ST_SCALE_X;
				end
			end
			ST_SCALE_X:   state_d = ST_SCALE_Y;
			ST_SCALE_Y:   state_d = ST_UPDATE;
			ST_UPDATE:    state_d = ST_YAW_START;
			ST_YAW_START: state_d = ST_TRIG_YAW;
			ST_TRIG_YAW: begin
				if (trig_rsp.done) begin
					state_d = ST_TRIG_PITCH;
				end
			end
			ST_TRIG_PITCH: begin
				if (trig_rsp.done) begin
					state_d = ST_MUL_X;
				end
			end
			ST_MUL_X: state_d = ST_MUL_Z;
			ST_MUL_Z: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: operand selects and unit start
	always_comb begin
		req.ready  = 1'b0;
		trig_start = 1'b0;
		trig_angle = signed'({1'b0, yaw_q});
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCALE_X: begin
				mul_a = 17'(cx_q) - 17'(last_x_q);
				mul_b = signed'({1'b0, sens_q});
			end
			ST_SCALE_Y: begin
				mul_a = 17'(last_y_q) - 17'(cy_q);
				mul_b = signed'({1'b0, sens_q});
			end
			ST_YAW_START: trig_start = 1'b1;
			ST_TRIG_YAW: begin
				trig_start = trig_rsp.done;
				trig_angle = 18'(pitch_q);
			end
			ST_MUL_X: begin
				mul_a = 17'(cy_trig_q);
				mul_b = 17'(cp_q);
			end
			ST_MUL_Z: begin
				mul_a = 17'(sy_q);
				mul_b = 17'(cp_q);
			end
			default: begin
				trig_start = 1'b0;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sens_q      <= SENS_RST;
			plim_q      <= PLIM_RST;
			last_x_q    <= START_X_RST;
			last_y_q    <= START_Y_RST;
			yaw_q       <= YAW_RST;
			pitch_q     <= '0;
			fov_q       <= FOV_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				case (cfg.index)
					REG_SENSITIVITY: sens_q   <= cfg.data;
					REG_PITCH_LIMIT: plim_q   <= cfg.data[14:0];
					REG_START_X:     last_x_q <= cfg.data;
					REG_START_Y:     last_y_q <= cfg.data;
					default: begin
						sens_q <= sens_q;
					end
				endcase
			end
			if (req_fire && req.operation == OP_SCROLL) begin
				fov_q <= fov_new[5:0];
			end
			if (state_q == ST_UPDATE) begin
				last_x_q <= cx_q;
				last_y_q <= cy_q;
				yaw_q    <= yaw_wrap[16:0];
				pitch_q  <= pitch_new[15:0];
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and output payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cx_q <= req.cursor_x;
			cy_q <= req.cursor_y;
		end
		case (state_q)
			ST_SCALE_X: prod_q <= mul_p;
			ST_SCALE_Y: begin
				prod_q <= mul_p;
				dyaw_q <= scale_r[17:0];
			end
			ST_TRIG_YAW: begin
				if (trig_rsp.done) begin
					sy_q      <= trig_rsp.sin_val;
					cy_trig_q <= trig_rsp.cos_val;
				end
			end
			ST_TRIG_PITCH: begin
				if (trig_rsp.done) begin
					sp_q <= trig_rsp.sin_val;
					cp_q <= trig_rsp.cos_val;
				end
			end
			ST_MUL_X: prod_q <= mul_p;
			ST_MUL_Z: begin
				prod_q <= mul_p;
				dirx_q <= q14_r[15:0];
			end
			ST_FINISH: begin
				if (out_free) begin
					o_dir_x_q <= dirx_q;
					o_dir_y_q <= sp_q;
					o_dir_z_q <= q14_r[15:0];
					o_yaw_q   <= yaw_q;
					o_pitch_q <= pitch_q;
					o_fov_q   <= fov_q;
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.dir_x       = o_dir_x_q;
	assign rsp.dir_y       = o_dir_y_q;
	assign rsp.dir_z       = o_dir_z_q;
	assign rsp.yaw_angle   = o_yaw_q;
	assign rsp.pitch_angle = o_pitch_q;
	assign rsp.fov_degrees = o_fov_q;

endmodule

`default_nettype wire

// File: sv/mlcd_checker.sv
// mouse-look camera direction: port-level checker and its bind to the top level
// sees only the top-level channel signals; no package dependency
`default_nettype none

module mlcd_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               req_valid,
	input wire               req_ready,
	input wire               rsp_valid,
	input wire               rsp_ready,
	input wire signed [15:0] rsp_dir_y,
	input wire [16:0]        rsp_yaw,
	input wire signed [15:0] rsp_pitch,
	input wire [5:0]         rsp_fov
);

	// a stalled result holds its yaw, pitch, fov and dir_y
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_yaw) && $stable(rsp_pitch)
			&& $stable(rsp_fov) && $stable(rsp_dir_y))
		else $error("result changed while stalled");

	// the block works on one event at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("event accepted while previous one in flight");

	// yaw wraps into one turn and fov stays clamped
	a_yaw_fov_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_yaw < 17'd92160 && rsp_fov >= 6'd1 && rsp_fov <= 6'd45)
		else $error("yaw or fov out of range");

	// pitch clamp and unit-range sine
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_pitch >= -16'sd23040 && rsp_pitch <= 16'sd23040
			&& rsp_dir_y >= -16'sd16384 && rsp_dir_y <= 16'sd16384)
		else $error("pitch or dir_y out of range");

endmodule

bind mouse_look_camera_direction_top mlcd_checker u_mlcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_dir_y(rsp.dir_y),
	.rsp_yaw  (rsp.yaw_angle),
	.rsp_pitch(rsp.pitch_angle),
	.rsp_fov  (rsp.fov_degrees)
);

`default_nettype wire

// File: tb/mouse_look_camera_direction_top_tb.sv
// self-checking testbench for mouse_look_camera_direction_top: yaw/pitch view tracker
// depends on mlcd_pkg, mlcd_if and the block itself; predicts every direction result
`timescale 1ns / 1ps

import mlcd_pkg::*;

// one direction result as the block reports it
typedef struct packed {
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic [16:0]        yaw;
	logic signed [15:0] pitch;
	logic [5:0]         fov;
} view_t;

// camera state predictor and result checker
class view_tracker;
	int iterations;
	int sensitivity;
	int pitch_lim;
	int last_x;
	int last_y;
	int yaw;
	int pitch;
	int fov;
	view_t expected_views[$];
	int fail_count;
	int reported;
	int checked;

	function new(int iters);
		iterations  = (iters > 24) ? 24 : iters;
		sensitivity = 6554;
		pitch_lim   = 22784;
		last_x      = 400;
		last_y      = 300;
		yaw         = 69120;
		pitch       = 0;
		fov         = 45;
		fail_count  = 0;
		reported    = 0;
		checked     = 0;
	endfunction

	static function longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// divide by 2^s, halves away from zero
	static function longint round_shift(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end
		return -((-v + half) >>> s);
	endfunction

	// arctangent of 2^-i in 2^-16 degree
	static function longint atan_step(int i);
		case (i)
			0:  return 2949120;
			1:  return 1740967;
			2:  return 919879;
			3:  return 466945;
			4:  return 234379;
			5:  return 117304;
			6:  return 58666;
			7:  return 29335;
			8:  return 14668;
			9:  return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			16: return 57;
			17: return 29;
			18: return 14;
			19: return 7;
			20: return 4;
			21: return 2;
			22: return 1;
			default: return 0;
		endcase
	endfunction

	// sine and cosine in q1.14 of an angle in 1/256 degree
	function void sin_cos(input int angle, output longint s, output longint c);
		longint a, x, y, z, t;
		bit flip;
		a    = angle;
		flip = 1'b0;
		while (a > 46080) a -= 92160;
		while (a <= -46080) a += 92160;
		// fold into the right half plane by a half turn
		if (a > 23040) begin
			a -= 46080;
			flip = 1'b1;
		end else if (a < -23040) begin
			a += 46080;
			flip = 1'b1;
		end
		z = a * 256;
		x = 652032874;
		y = 0;
		for (int i = 0; i < iterations; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_step(i);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_step(i);
			end
			x = t;
		end
		x = clip(round_shift(x, 16), -16384, 16384);
		y = clip(round_shift(y, 16), -16384, 16384);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function longint mul_q14(longint a, longint b);
		return clip(round_shift(a * b, 14), -16384, 16384);
	endfunction

	function longint scale_pixels(longint px);
		return clip(round_shift(px * sensitivity, 8), -92159, 92159);
	endfunction

	function void set_reg(mlcd_reg_t idx, logic [15:0] d);
		case (idx)
			REG_SENSITIVITY: sensitivity = int'(d);
			REG_PITCH_LIMIT: pitch_lim = int'(d[14:0]);
			REG_START_X:     last_x = int'($signed(d));
			REG_START_Y:     last_y = int'($signed(d));
			default: ;
		endcase
	endfunction

	// update the camera for one accepted event and queue the view it gives
	function void note_event(logic op, logic signed [15:0] cx, logic signed [15:0] cy,
		logic signed [7:0] step);
		longint d_yaw, d_pitch, lim, ny, sy, cyw, sp, cp;
		view_t v;
		if (op == OP_MOVE) begin
			d_yaw   = scale_pixels(longint'(cx) - last_x);
			d_pitch = scale_pixels(longint'(last_y) - cy);
			lim     = (pitch_lim > 23040) ? 23040 : pitch_lim;
			ny      = yaw + d_yaw;
			last_x  = cx;
			last_y  = cy;
			if (ny < 0) begin
				ny += 92160;
			end else if (ny >= 92160) begin
				ny -= 92160;
			end
			yaw   = int'(ny);
			pitch = int'(clip(pitch + d_pitch, -lim, lim));
		end else begin
			fov = int'(clip(longint'(fov) - step, 1, 45));
		end
		sin_cos(yaw, sy, cyw);
		sin_cos(pitch, sp, cp);
		v.dir_x = 16'(mul_q14(cyw, cp));
		v.dir_y = 16'(sp);
		v.dir_z = 16'(mul_q14(sy, cp));
		v.yaw   = 17'(yaw);
		v.pitch = 16'(pitch);
		v.fov   = 6'(fov);
		expected_views.push_back(v);
	endfunction

	function int outstanding();
		return expected_views.size();
	endfunction

	function void check_view(view_t got);
		view_t want;
		if (expected_views.size() == 0) begin
			fail_count++;
			if (reported < 10) begin
				reported++;
				$display("unexpected view: dir %0d %0d %0d yaw %0d pitch %0d fov %0d",
					got.dir_x, got.dir_y, got.dir_z, got.yaw, got.pitch, got.fov);
			end
			return;
		end
		want = expected_views.pop_front();
		checked++;
		if (got.dir_x !== want.dir_x || got.dir_y !== want.dir_y ||
			got.dir_z !== want.dir_z || got.yaw !== want.yaw ||
			got.pitch !== want.pitch || got.fov !== want.fov) begin
			fail_count++;
			if (reported < 10) begin
				reported++;
				$display("view mismatch at result %0d: expected dir %0d %0d %0d yaw %0d pitch %0d fov %0d",
					checked, want.dir_x, want.dir_y, want.dir_z, want.yaw, want.pitch, want.fov);
				$display("                     got      dir %0d %0d %0d yaw %0d pitch %0d fov %0d",
					got.dir_x, got.dir_y, got.dir_z, got.yaw, got.pitch, got.fov);
			end
		end
	endfunction
endclass

module mouse_look_camera_direction_top_tb;

	localparam int TRIG_ITER    = 16;
	localparam int SETTLE_CYC   = 2 * TRIG_ITER + 30;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 160;

	logic clk;
	logic arst_n;
	int   cycles;
	int   tx_idle;
	int   rx_idle;
	int   n_moves;
	int   n_scrolls;
	int   n_writes;
	int   n_settings;
	view_t got_view;

	view_tracker sb;

	mlcd_in_if  req_if ();
	mlcd_out_if rsp_if ();
	mlcd_cfg_if cfg_if ();

	mouse_look_camera_direction_top #(
		.TRIG_ITERATIONS(TRIG_ITER)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if.sink),
		.rsp   (rsp_if.source),
		.cfg   (cfg_if.sink)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("mouse_look_camera_direction_top regression: fail");
			$finish;
		end
	end

	// result side: check each transaction, stall at random
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got_view.dir_x = rsp_if.dir_x;
				got_view.dir_y = rsp_if.dir_y;
				got_view.dir_z = rsp_if.dir_z;
				got_view.yaw   = rsp_if.yaw_angle;
				got_view.pitch = rsp_if.pitch_angle;
				got_view.fov   = rsp_if.fov_degrees;
				sb.check_view(got_view);
			end
			rsp_if.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// one event transaction; the unused fields carry random bits
	task automatic send_event(logic op, logic signed [15:0] x, logic signed [15:0] y,
		logic signed [7:0] step);
		if (op == OP_MOVE) begin
			step = 8'($urandom);
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
		end
		while ($urandom_range(99) < tx_idle) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.operation   <= op;
		req_if.cursor_x    <= x;
		req_if.cursor_y    <= y;
		req_if.scroll_step <= step;
		do @(posedge clk); while (!req_if.ready);
		sb.note_event(op, x, y, step);
		if (op == OP_MOVE) begin
			n_moves++;
		end else begin
			n_scrolls++;
		end
	endtask

	// let every outstanding view arrive and the block drain
	task automatic settle();
		req_if.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write all four registers back to back while idle
	task automatic write_config(logic [15:0] sens, logic [15:0] plim, logic [15:0] sx,
		logic [15:0] sy);
		mlcd_reg_t   idx [4];
		logic [15:0] val [4];
		idx = '{REG_SENSITIVITY, REG_PITCH_LIMIT, REG_START_X, REG_START_Y};
		val = '{sens, plim, sx, sy};
		settle();
		for (int i = 0; i < 4; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx[i];
			cfg_if.data  <= val[i];
			do @(posedge clk); while (!cfg_if.ready);
			sb.set_reg(idx[i], val[i]);
			n_writes++;
		end
		cfg_if.valid <= 1'b0;
		n_settings++;
	endtask

	// mostly smooth mouse paths, some jumps, some scrolls
	task automatic random_event();
		int pick, span, nx, ny;
		pick = $urandom_range(99);
		if (pick < 65) begin
			span = ($urandom_range(9) == 0) ? 3000 : 60;
			nx   = sb.last_x + int'($urandom_range(2 * span)) - span;
			ny   = sb.last_y + int'($urandom_range(2 * span)) - span;
			send_event(OP_MOVE, 16'(sb.clip(nx, -32768, 32767)),
				16'(sb.clip(ny, -32768, 32767)), 8'sd0);
		end else if (pick < 80) begin
			send_event(OP_MOVE, 16'($urandom), 16'($urandom), 8'sd0);
		end else if (pick < 95) begin
			send_event(OP_SCROLL, 16'sd0, 16'sd0, 8'(int'($urandom_range(12)) - 6));
		end else begin
			send_event(OP_SCROLL, 16'sd0, 16'sd0, 8'($urandom));
		end
	endtask

	// stimulus
	initial begin
		logic [15:0] sens, plim;
		sb           = new(TRIG_ITER);
		n_moves      = 0;
		n_scrolls    = 0;
		n_writes     = 0;
		n_settings   = 0;
		tx_idle      = 6;
		rx_idle      = 80;
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.operation   <= OP_MOVE;
		req_if.cursor_x    <= 16'sd0;
		req_if.cursor_y    <= 16'sd0;
		req_if.scroll_step <= 8'sd0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_SENSITIVITY;
		cfg_if.data  <= 16'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view, field of view clamps at both ends
		send_event(OP_SCROLL, 16'sd0, 16'sd0, 8'sd0);
		send_event(OP_SCROLL, 16'sd0, 16'sd0, 8'sd127);
		send_event(OP_SCROLL, 16'sd0, 16'sd0, -8'sd128);
		send_event(OP_SCROLL, 16'sd0, 16'sd0, 8'sd1);
		send_event(OP_SCROLL, 16'sd0, 16'sd0, -8'sd1);
		// no motion, then saturating deltas into both pitch limits
		send_event(OP_MOVE, 16'sd400, 16'sd300, 8'sd0);
		send_event(OP_MOVE, 16'sd32767, -16'sd32768, 8'sd0);
		send_event(OP_MOVE, -16'sd32768, 16'sd32767, 8'sd0);
		send_event(OP_MOVE, -16'sd32768, 16'sd32767, 8'sd0);

		// full gain, pitch limit above a quarter turn, start at the corners
		write_config(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_event(OP_MOVE, 16'sd32767, -16'sd32768, 8'sd0);
		send_event(OP_MOVE, 16'sd32767, -16'sd32767, 8'sd0);
		send_event(OP_MOVE, -16'sd32768, 16'sd32767, 8'sd0);

		// half-pixel gain shows rounding of halves; zero pitch limit
		write_config(16'd128, 16'd0, 16'd0, 16'd0);
		send_event(OP_MOVE, 16'sd1, -16'sd1, 8'sd0);
		send_event(OP_MOVE, 16'sd0, 16'sd0, 8'sd0);
		send_event(OP_MOVE, 16'sd3, 16'sd5, 8'sd0);
		send_event(OP_SCROLL, 16'sd0, 16'sd0, 8'sd20);

		// zero gain, pitch limit exactly a quarter turn
		write_config(16'd0, 16'd23040, 16'd400, 16'd300);
		send_event(OP_MOVE, 16'sd1000, -16'sd1000, 8'sd0);
		write_config(16'd6554, 16'd23040, 16'd400, 16'd300);
		send_event(OP_MOVE, 16'sd400, -16'sd2000, 8'sd0);
		send_event(OP_MOVE, 16'sd9000, 16'sd300, 8'sd0);

		// random phases, each under a fresh setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(3))
				0:       sens = 16'hFFFF;
				1:       sens = 16'($urandom_range(1, 255));
				2:       sens = 16'($urandom_range(2000, 12000));
				default: sens = 16'($urandom);
			endcase
			case ($urandom_range(3))
				0:       plim = 16'd23040;
				1:       plim = 16'($urandom_range(23041, 32767));
				2:       plim = 16'($urandom_range(0, 23040));
				default: plim = 16'($urandom_range(0, 200));
			endcase
			write_config(sens, plim, 16'($urandom), 16'($urandom));
			// sender rarely idle first, then receiver rarely idle, then no idling
			if (ph < 2) begin
				tx_idle = 6;
				rx_idle = 80;
			end else if (ph < 4) begin
				tx_idle = 80;
				rx_idle = 6;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			repeat (PHASE_ITEMS) random_event();
		end

		settle();
		sb.fail_count += sb.outstanding();
		$display("covered %0d cursor moves and %0d scrolls under %0d register settings (%0d writes)",
			n_moves, n_scrolls, n_settings, n_writes);
		$display("checked %0d direction results, %0d failures", sb.checked, sb.fail_count);
		if (sb.fail_count == 0) begin
			$display("mouse_look_camera_direction_top regression: pass");
		end else begin
			$display("mouse_look_camera_direction_top regression: fail");
		end
		$finish;
	end

endmodule
